### sv/assert_macros.svh
// assertion shorthands, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define BTFF_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define BTFF_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

### sv/btff_pkg.sv
package btff_pkg;

  localparam int HEAP_BYTES      = 4096;
  localparam int TAG_BYTES       = 8;
  localparam int TAG_SH          = $clog2(TAG_BYTES);
  localparam int HEAP_WORDS      = HEAP_BYTES / TAG_BYTES;
  localparam int ADDR_W          = $clog2(HEAP_WORDS);
  localparam int BLK_W           = ADDR_W + 1;
  localparam int SZ_W            = $clog2(HEAP_WORDS + 1);
  localparam int ADD_W           = BLK_W + 1;
  localparam int TAG_W           = SZ_W + TAG_SH;
  localparam int MIN_SPLIT_WORDS = 3;
  localparam int REQ_W           = 16;
  localparam int OFF_W           = 12;
  localparam int NEED_W          = REQ_W + 2 - TAG_SH;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } btff_op_t;

  typedef enum logic [3:0] {
    ST_INIT_H,
    ST_INIT_T,
    ST_IDLE,
    ST_CHK,
    ST_FIT,
    ST_CHKN,
    ST_PREV,
    ST_CHKP,
    ST_MERGEP,
    ST_WRH,
    ST_WRT,
    ST_ADV,
    ST_RESP
  } btff_state_t;

  typedef enum logic [1:0] {
    K_ZERO,
    K_ONE,
    K_MONE
  } btff_k_t;

endpackage

### sv/btff_if.sv
interface btff_in_if
  import btff_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             op;
  logic [REQ_W-1:0] req_bytes;
  logic [OFF_W-1:0] free_offset;

  modport source (output valid, op, req_bytes, free_offset, input ready);
  modport sink (input valid, op, req_bytes, free_offset, output ready);
endinterface

interface btff_out_if
  import btff_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             ok;
  logic [OFF_W-1:0] payload_offset;

  modport source (output valid, ok, payload_offset, input ready);
  modport sink (input valid, ok, payload_offset, output ready);
endinterface

### sv/btff_ram.sv
module btff_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/boundary_tag_first_fit_allocator.sv
// allocate: scan to the first fitting block, then write its tags (and those of the
// remainder when the block is split); free: scan to the target block, merge with free
// neighbours and write; a failed scan or a request rejected on entry goes straight to the
// response; the scan visits block headers one per cycle through the single read port of the tag ram
// the next item is taken in the cycle after the result is handed to the output register
// reset: synchronous, rst_n low; afterwards the INIT_H and INIT_T states write the initial tags, not ready
`include "assert_macros.svh"

module boundary_tag_first_fit_allocator
  import btff_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  btff_in_if.sink      in_ch,
  btff_out_if.source   out_ch
);

  btff_state_t      state_r, state_nxt;
  btff_op_t         op_r, op_nxt;
  logic [SZ_W-1:0]  need_r, need_nxt;
  logic [SZ_W-1:0]  sz_r, sz_nxt;
  logic [SZ_W-1:0]  rest_r, rest_nxt;
  logic [BLK_W-1:0] blk_r, blk_nxt;
  logic [BLK_W-1:0] target_r, target_nxt;
  logic             use_r, use_nxt;
  logic             split_r, split_nxt;
  logic             res_ok_r, res_ok_nxt;
  logic [OFF_W-1:0] res_off_r, res_off_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_ok_r, out_ok_nxt;
  logic [OFF_W-1:0] out_off_r, out_off_nxt;

  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [TAG_W-1:0]  mem_wdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [TAG_W-1:0]  mem_rdata;

  logic [ADD_W-1:0] alu_a, alu_b, alu_kval, alu_y;
  logic             alu_inv;
  btff_k_t          alu_k;

  logic [SZ_W-1:0]   rd_sz;
  logic              rd_used;
  logic              in_xfer, out_xfer, out_load;
  logic              chk_fit, at_target, y_end, prev_merge;
  logic [REQ_W:0]    req_round;
  logic [NEED_W-1:0] need_w;
  logic              too_big, bad_free, early_fail;
  logic [BLK_W-1:0]  target_w;
  logic              wr_phase;

  btff_ram #(
    .WIDTH (TAG_W),
    .DEPTH (HEAP_WORDS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign in_ch.ready           = (state_r == ST_IDLE);
  assign out_ch.valid          = out_valid_r;
  assign out_ch.ok             = out_ok_r;
  assign out_ch.payload_offset = out_off_r;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign out_load = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  assign rd_sz   = mem_rdata[TAG_W-1:TAG_SH];
  assign rd_used = mem_rdata[0];

  // request conditioning at the input transfer
  assign req_round  = {1'b0, in_ch.req_bytes} + (REQ_W+1)'(TAG_BYTES - 1);
  assign need_w     = NEED_W'(req_round >> TAG_SH) + NEED_W'(2);
  assign too_big    = need_w > NEED_W'(HEAP_WORDS);
  assign bad_free   = (in_ch.free_offset < OFF_W'(TAG_BYTES)) ||
                      (in_ch.free_offset[TAG_SH-1:0] != '0) ||
                      (32'(in_ch.free_offset >> TAG_SH) > 32'(HEAP_WORDS));
  assign target_w   = BLK_W'(in_ch.free_offset >> TAG_SH) - BLK_W'(1);
  assign early_fail = (btff_op_t'(in_ch.op) == OP_ALLOC) ? too_big : bad_free;

  assign chk_fit    = !rd_used && (rd_sz >= need_r);
  assign at_target  = (blk_r == target_r);
  assign y_end      = alu_y >= ADD_W'(HEAP_WORDS);
  assign prev_merge = (rd_sz != '0) && (BLK_W'(rd_sz) <= blk_r) && !rd_used;

  assign wr_phase = (state_r == ST_WRH) || (state_r == ST_WRT) ||
                    (state_r == ST_INIT_H) || (state_r == ST_INIT_T);

  // shared adder: y = a + (b or ~b) + k
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_inv = 1'b0;
    alu_k   = K_ZERO;
    unique case (state_r)
      ST_CHK: begin
        alu_a = ADD_W'(blk_r);
        if (op_r == OP_ALLOC && chk_fit) begin
          alu_k = K_ONE;
        end else begin
          alu_b = ADD_W'(rd_sz);
        end
      end
      ST_FIT: begin
        alu_a   = ADD_W'(sz_r);
        alu_b   = ADD_W'(need_r);
        alu_inv = 1'b1;
        alu_k   = K_ONE;
      end
      ST_CHKN: begin
        alu_a = ADD_W'(sz_r);
        alu_b = ADD_W'(rd_sz);
      end
      ST_PREV: begin
        alu_a = ADD_W'(blk_r);
        alu_k = K_MONE;
      end
      ST_CHKP: begin
        alu_a   = ADD_W'(blk_r);
        alu_b   = ADD_W'(rd_sz);
        alu_inv = 1'b1;
        alu_k   = K_ONE;
      end
      ST_MERGEP: begin
        alu_a = ADD_W'(sz_r);
        alu_b = ADD_W'(rest_r);
      end
      ST_WRT: begin
        alu_a = ADD_W'(blk_r);
        alu_b = ADD_W'(sz_r);
        alu_k = K_MONE;
      end
      ST_ADV: begin
        alu_a = ADD_W'(blk_r);
        alu_b = ADD_W'(sz_r);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    case (alu_k)
      K_ONE:   alu_kval = ADD_W'(1);
      K_MONE:  alu_kval = '1;
      default: alu_kval = '0;
    endcase
  end

  assign alu_y = alu_a + (alu_inv ? ~alu_b : alu_b) + alu_kval;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_INIT_H: state_nxt = ST_INIT_T;
      ST_INIT_T: state_nxt = ST_IDLE;
      ST_IDLE: begin
        if (in_xfer) begin
          state_nxt = early_fail ? ST_RESP : ST_CHK;
        end
      end
      ST_CHK: begin
        if (rd_sz == '0) begin
          state_nxt = ST_RESP;
        end else if (op_r == OP_ALLOC) begin
          if (chk_fit) begin
            state_nxt = ST_FIT;
          end else begin
            state_nxt = y_end ? ST_RESP : ST_CHK;
          end
        end else if (at_target) begin
          if (!rd_used) begin
            state_nxt = ST_RESP;
          end else if (!y_end) begin
            state_nxt = ST_CHKN;
          end else if (blk_r != '0) begin
            state_nxt = ST_PREV;
          end else begin
            state_nxt = ST_WRH;
          end
        end else begin
          state_nxt = y_end ? ST_RESP : ST_CHK;
        end
      end
      ST_FIT:    state_nxt = ST_WRH;
      ST_CHKN:   state_nxt = (blk_r != '0) ? ST_PREV : ST_WRH;
      ST_PREV:   state_nxt = ST_CHKP;
      ST_CHKP:   state_nxt = prev_merge ? ST_MERGEP : ST_WRH;
      ST_MERGEP: state_nxt = ST_WRH;
      ST_WRH:    state_nxt = ST_WRT;
      ST_WRT:    state_nxt = split_r ? ST_ADV : ST_RESP;
      ST_ADV:    state_nxt = ST_WRH;
      ST_RESP: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default:   state_nxt = ST_INIT_H;
    endcase
  end

  // datapath and tag ram control
  always_comb begin
    op_nxt        = op_r;
    need_nxt      = need_r;
    sz_nxt        = sz_r;
    rest_nxt      = rest_r;
    blk_nxt       = blk_r;
    target_nxt    = target_r;
    use_nxt       = use_r;
    split_nxt     = split_r;
    res_ok_nxt    = res_ok_r;
    res_off_nxt   = res_off_r;
    out_valid_nxt = out_valid_r;
    out_ok_nxt    = out_ok_r;
    out_off_nxt   = out_off_r;
    mem_we        = 1'b0;
    mem_waddr     = blk_r[ADDR_W-1:0];
    mem_wdata     = {sz_r, {(TAG_SH-1){1'b0}}, use_r};
    mem_raddr     = '0;

    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_INIT_H: begin
        mem_we    = 1'b1;
        mem_waddr = '0;
        mem_wdata = {SZ_W'(HEAP_WORDS), {TAG_SH{1'b0}}};
      end
      ST_INIT_T: begin
        mem_we    = 1'b1;
        mem_waddr = ADDR_W'(HEAP_WORDS - 1);
        mem_wdata = {SZ_W'(HEAP_WORDS), {TAG_SH{1'b0}}};
      end
      ST_IDLE: begin
        if (in_xfer) begin
          op_nxt      = btff_op_t'(in_ch.op);
          need_nxt    = SZ_W'(need_w);
          target_nxt  = target_w;
          blk_nxt     = '0;
          res_ok_nxt  = 1'b0;
          res_off_nxt = '0;
        end
      end
      ST_CHK: begin
        if (rd_sz != '0) begin
          if (op_r == OP_ALLOC && chk_fit) begin
            sz_nxt      = rd_sz;
            res_ok_nxt  = 1'b1;
            res_off_nxt = OFF_W'({alu_y, {TAG_SH{1'b0}}});
          end else if (op_r == OP_FREE && at_target) begin
            if (rd_used) begin
              sz_nxt     = rd_sz;
              use_nxt    = 1'b0;
              split_nxt  = 1'b0;
              res_ok_nxt = 1'b1;
              // header of the following block
              mem_raddr  = alu_y[ADDR_W-1:0];
            end
          end else begin
            blk_nxt   = alu_y[BLK_W-1:0];
            mem_raddr = alu_y[ADDR_W-1:0];
          end
        end
      end
      ST_FIT: begin
        rest_nxt = alu_y[SZ_W-1:0];
        use_nxt  = 1'b1;
        if (alu_y >= ADD_W'(MIN_SPLIT_WORDS)) begin
          split_nxt = 1'b1;
          sz_nxt    = need_r;
        end else begin
          split_nxt = 1'b0;
        end
      end
      ST_CHKN: begin
        if (!rd_used) begin
          sz_nxt = alu_y[SZ_W-1:0];
        end
      end
      ST_PREV: begin
        // trailer of the preceding block
        mem_raddr = alu_y[ADDR_W-1:0];
      end
      ST_CHKP: begin
        if (prev_merge) begin
          blk_nxt  = alu_y[BLK_W-1:0];
          rest_nxt = rd_sz;
        end
      end
      ST_MERGEP: begin
        sz_nxt = alu_y[SZ_W-1:0];
      end
      ST_WRH: begin
        mem_we = 1'b1;
      end
      ST_WRT: begin
        mem_we    = 1'b1;
        mem_waddr = alu_y[ADDR_W-1:0];
      end
      ST_ADV: begin
        // remainder of a split becomes a free block
        blk_nxt   = alu_y[BLK_W-1:0];
        sz_nxt    = rest_r;
        use_nxt   = 1'b0;
        split_nxt = 1'b0;
      end
      ST_RESP: begin
        if (out_load) begin
          out_valid_nxt = 1'b1;
          out_ok_nxt    = res_ok_r;
          out_off_nxt   = res_off_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT_H;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r      <= op_nxt;
    need_r    <= need_nxt;
    sz_r      <= sz_nxt;
    rest_r    <= rest_nxt;
    blk_r     <= blk_nxt;
    target_r  <= target_nxt;
    use_r     <= use_nxt;
    split_r   <= split_nxt;
    res_ok_r  <= res_ok_nxt;
    res_off_r <= res_off_nxt;
    out_ok_r  <= out_ok_nxt;
    out_off_r <= out_off_nxt;
  end

  `BTFF_ASSERT_IMP(a_we_state, mem_we, wr_phase, "tag write outside a write state")
  `BTFF_ASSERT_IMP(a_we_size, mem_we, mem_wdata[TAG_W-1:TAG_SH] != '0, "zero-size tag write")
  `BTFF_ASSERT_IMP(a_fail_zero, out_valid_r && !out_ok_r, out_off_r == '0, "offset on failure")
  `BTFF_ASSERT_IMP(a_scan_range, state_r == ST_CHK, blk_r < BLK_W'(HEAP_WORDS), "scan past end")
  `BTFF_ASSERT_IMP(a_init_after_rst, $past(!rst_n), state_r == ST_INIT_H, "no init after reset")

endmodule
